// ===== sv/mcdg_pkg.sv =====
// Package: shared constants, types and small table functions for the calendar day generator.
package mcdg_pkg;

  localparam logic [13:0] YEAR_LIMIT    = 14'd9999;
  localparam logic [13:0] JULIAN_LAST   = 14'd1581;
  localparam logic [13:0] GREG_FIRST    = 14'd1582;
  // leaps of the Gregorian rule through 1581 plus the ten dropped days
  localparam logic [21:0] GREG_ADJUST   = 22'd393;
  localparam logic [12:0] RECIP_100     = 13'd5243;   // ceil(2^19 / 100)
  localparam logic [21:0] CYCLE_35      = 22'd35;

  localparam logic [4:0]  SETUP_LAST    = 5'd11;
  localparam logic [4:0]  REDUCE_TOP    = 5'd16;

  localparam logic        CMD_ADD_HOLIDAY = 1'b0;
  localparam logic        CMD_GENERATE    = 1'b1;

  localparam logic [2:0]  WD_SUN = 3'd0;
  localparam logic [2:0]  WD_FRI = 3'd5;
  localparam logic [2:0]  WD_SAT = 3'd6;
  localparam logic [2:0]  MK_LAST = 3'd4;

  localparam logic [1:0]  CLR_BLACK = 2'd0;
  localparam logic [1:0]  CLR_RED   = 2'd1;
  localparam logic [1:0]  CLR_GREEN = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } gen_state_t;

  typedef enum logic [1:0] {
    CP_IDLE,
    CP_SETUP,
    CP_REDUCE
  } calc_phase_t;

  typedef struct packed {
    logic       done;
    logic       leap;
    logic [5:0] rem35;
  } calc_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    begin
      case (m)
        4'd2:                       n = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
        default:                    n = 5'd31;
      endcase
      return n;
    end
  endfunction

  function automatic logic [8:0] month_offset(input logic [3:0] m, input logic leap);
    logic [8:0] n;
    begin
      case (m)
        4'd1:    n = 9'd0;
        4'd2:    n = 9'd31;
        4'd3:    n = 9'd59;
        4'd4:    n = 9'd90;
        4'd5:    n = 9'd120;
        4'd6:    n = 9'd151;
        4'd7:    n = 9'd181;
        4'd8:    n = 9'd212;
        4'd9:    n = 9'd243;
        4'd10:   n = 9'd273;
        4'd11:   n = 9'd304;
        4'd12:   n = 9'd334;
        default: n = 9'd0;
      endcase
      if (leap && (m > 4'd2)) begin
        n = n + 9'd1;
      end
      return n;
    end
  endfunction

  // x below 42
  function automatic logic [2:0] mod7_small(input logic [5:0] x);
    logic [5:0] t;
    begin
      t = x;
      if (t >= 6'd35) t = t - 6'd35;
      if (t >= 6'd28) t = t - 6'd28;
      if (t >= 6'd14) t = t - 6'd14;
      if (t >= 6'd7)  t = t - 6'd7;
      return t[2:0];
    end
  endfunction

  // x below 40
  function automatic logic [2:0] mod5_small(input logic [5:0] x);
    logic [5:0] t;
    begin
      t = x;
      if (t >= 6'd20) t = t - 6'd20;
      if (t >= 6'd10) t = t - 6'd10;
      if (t >= 6'd5)  t = t - 6'd5;
      return t[2:0];
    end
  endfunction

endpackage

// ===== sv/mcdg_calc.sv =====
// Iterative day-count unit: day count before the month, reduced mod 35, plus leap flag.
module mcdg_calc (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [13:0]            year,
  input  logic [3:0]             month,
  output mcdg_pkg::calc_stat_t   stat
);
  import mcdg_pkg::*;

  calc_phase_t phase_r, phase_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [21:0] acc_r, acc_nxt;
  logic [6:0]  q_r, q_nxt;
  logic        leap_r, leap_nxt;
  logic        done_r, done_nxt;
  logic [13:0] yr_r;
  logic [13:0] ym1_r;
  logic [3:0]  mon_r;

  logic        greg;
  logic [13:0] jul;
  logic [13:0] mult_in;
  logic [26:0] prod;
  logic [13:0] q_x100;
  logic        rem100_zero;
  logic        leap_calc;
  logic [21:0] opnd;
  logic        do_sub;
  logic [21:0] alu_out;

  assign greg    = (ym1_r >= GREG_FIRST);
  assign jul     = (ym1_r > JULIAN_LAST) ? JULIAN_LAST : ym1_r;
  assign prod    = {13'd0, mult_in} * {14'd0, RECIP_100};
  assign q_x100  = (14'(q_r) << 6) + (14'(q_r) << 5) + (14'(q_r) << 2);
  assign rem100_zero = (yr_r == q_x100);
  assign leap_calc = (yr_r > JULIAN_LAST)
                   ? ((yr_r[1:0] == 2'd0) && (!rem100_zero || (q_r[1:0] == 2'd0)))
                   : (yr_r[1:0] == 2'd0);
  assign alu_out = do_sub ? (acc_r - opnd) : (acc_r + opnd);

  always_comb begin
    unique case (step_r)
      5'd0:    mult_in = yr_r;
      5'd2:    mult_in = ym1_r >> 2;
      default: mult_in = ym1_r;
    endcase
  end

  // operand select for the shared add/subtract unit
  always_comb begin
    opnd   = '0;
    do_sub = 1'b0;
    if (phase_r == CP_REDUCE) begin
      opnd   = CYCLE_35 << step_r;
      do_sub = (acc_r >= opnd);
      if (!do_sub) opnd = '0;
    end else begin
      case (step_r)
        5'd0:  opnd = 22'(ym1_r);
        5'd1:  opnd = 22'(ym1_r) << 2;
        5'd2:  begin opnd = greg ? 22'(q_r) : '0; do_sub = 1'b1; end
        5'd3:  opnd = greg ? 22'(q_r) : '0;
        5'd4:  opnd = 22'(ym1_r) << 5;
        5'd5:  opnd = 22'(ym1_r) << 6;
        5'd6:  opnd = 22'(ym1_r) << 8;
        5'd7:  opnd = 22'(jul >> 2);
        5'd8:  opnd = greg ? 22'(ym1_r >> 2) : '0;
        5'd9:  begin opnd = greg ? GREG_ADJUST : '0; do_sub = 1'b1; end
        5'd10: opnd = 22'(ym1_r) << 3;
        5'd11: opnd = 22'(month_offset(mon_r, leap_r));
        default: opnd = '0;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    leap_nxt  = leap_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      CP_IDLE: begin
        if (go) begin
          phase_nxt = CP_SETUP;
          step_nxt  = '0;
          acc_nxt   = '0;
        end
      end
      CP_SETUP: begin
        acc_nxt = alu_out;
        if (step_r <= 5'd2) q_nxt = prod[25:19];
        if (step_r == 5'd1) leap_nxt = leap_calc;
        if (step_r == SETUP_LAST) begin
          phase_nxt = CP_REDUCE;
          step_nxt  = REDUCE_TOP;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      CP_REDUCE: begin
        acc_nxt = alu_out;
        if (step_r == 5'd0) begin
          phase_nxt = CP_IDLE;
          done_nxt  = 1'b1;
        end else begin
          step_nxt = step_r - 5'd1;
        end
      end
      default: phase_nxt = CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= CP_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    leap_r <= leap_nxt;
    if (go && (phase_r == CP_IDLE)) begin
      yr_r  <= year;
      ym1_r <= year - 14'd1;
      mon_r <= month;
    end
  end

  assign stat.done  = done_r;
  assign stat.leap  = leap_r;
  assign stat.rem35 = acc_r[5:0];

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("calc done held");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < CYCLE_35)) else $error("remainder not reduced");
  a_reduce_order: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == CP_REDUCE) |-> $past(phase_r == CP_SETUP || phase_r == CP_REDUCE))
    else $error("reduce entered out of order");
`endif

endmodule

// ===== sv/month_calendar_day_generator_unit.sv =====
// Top level: command decode, holiday bitmap and per-day result sequencer.
// A generate beat runs the day-count unit, then the block shows one day result per cycle;
//   busy stays high through the calculation and while the month's days are emitted.
// The day-count unit is iterative: 12 add/sub steps, then a
//   17-step compare-subtract reduction mod 35 on one shared 22-bit adder.
// Add-holiday beats and generate beats with a bad month never start the day-count unit.
// Reset (rst_n low, synchronous) clears the bitmap and the sequencer; no clear sweep.
module month_calendar_day_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  output logic        out_valid,
  output logic [4:0]  out_day_of_month,
  output logic [2:0]  out_weekday,
  output logic [2:0]  out_market_day,
  output logic [2:0]  out_week_row,
  output logic        out_holiday_flag,
  output logic [1:0]  out_color_class,
  output logic        out_last_day
);
  import mcdg_pkg::*;

  gen_state_t  state_r, state_nxt;

  // holiday bitmap: one 31-bit row per month, read at the current month only
  logic [30:0] hmap_r [12];

  logic [3:0]  mon_idx_r;     // month - 1
  logic [3:0]  month_r;
  logic [4:0]  len_r;
  logic [4:0]  day_r;
  logic [2:0]  wd_r;
  logic [2:0]  mk_r;
  logic [2:0]  row_r;

  logic        out_valid_r;
  logic [4:0]  out_dom_r;
  logic [2:0]  out_wd_r;
  logic [2:0]  out_mk_r;
  logic [2:0]  out_row_r;
  logic        out_hol_r;
  logic [1:0]  out_clr_r;
  logic        out_last_r;

  logic        accept;
  logic        month_ok;
  logic        gen_go;
  logic [13:0] year_sat;
  logic        hol_now;
  logic        last_now;
  logic [1:0]  clr_now;
  calc_stat_t  calc_stat;

  assign accept   = start && !busy;
  assign month_ok = (in_month >= 4'd1) && (in_month <= 4'd12);
  assign gen_go   = accept && month_ok && (in_command == CMD_GENERATE);
  assign year_sat = (in_year == 14'd0) ? 14'd1
                  : ((in_year > YEAR_LIMIT) ? YEAR_LIMIT : in_year);

  assign hol_now  = hmap_r[mon_idx_r][day_r - 5'd1];
  assign last_now = (day_r == len_r);
  always_comb begin
    if (hol_now || (wd_r == WD_SUN)) clr_now = CLR_RED;
    else if (wd_r == WD_FRI)         clr_now = CLR_GREEN;
    else                             clr_now = CLR_BLACK;
  end

  mcdg_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (gen_go),
    .year  (year_sat),
    .month (in_month),
    .stat  (calc_stat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (gen_go) state_nxt = ST_CALC;
      ST_CALC: if (calc_stat.done) state_nxt = ST_EMIT;
      ST_EMIT: if (last_now) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 12; i++) hmap_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EMIT);
      if (accept && month_ok && (in_command == CMD_ADD_HOLIDAY) && (in_day != 5'd0)) begin
        hmap_r[in_month - 4'd1][in_day - 5'd1] <= 1'b1;
      end
    end
  end

  // day counters and result beat registers
  always_ff @(posedge clk) begin
    if (gen_go) begin
      month_r   <= in_month;
      mon_idx_r <= in_month - 4'd1;
    end
    if ((state_r == ST_CALC) && calc_stat.done) begin
      // day 1 has count base + 1: weekday (base + 6) mod 7, market (base + 1) mod 5
      wd_r  <= mod7_small(calc_stat.rem35 + 6'd6);
      mk_r  <= mod5_small(calc_stat.rem35 + 6'd1);
      day_r <= 5'd1;
      row_r <= '0;
      len_r <= month_len(month_r, calc_stat.leap);
    end
    if (state_r == ST_EMIT) begin
      out_dom_r  <= day_r;
      out_wd_r   <= wd_r;
      out_mk_r   <= mk_r;
      out_row_r  <= row_r;
      out_hol_r  <= hol_now;
      out_clr_r  <= clr_now;
      out_last_r <= last_now;
      day_r <= day_r + 5'd1;
      wd_r  <= (wd_r == WD_SAT) ? WD_SUN : wd_r + 3'd1;
      mk_r  <= (mk_r == MK_LAST) ? 3'd0 : mk_r + 3'd1;
      if (wd_r == WD_SAT) row_r <= row_r + 3'd1;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_day_of_month = out_dom_r;
  assign out_weekday      = out_wd_r;
  assign out_market_day   = out_mk_r;
  assign out_week_row     = out_row_r;
  assign out_holiday_flag = out_hol_r;
  assign out_color_class  = out_clr_r;
  assign out_last_day     = out_last_r;

`ifndef SYNTH
  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EMIT)) else $error("result beat outside emit");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r) else $error("beat after last day");
  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_wd_r <= WD_SAT && out_mk_r <= MK_LAST && out_dom_r != 5'd0))
    else $error("day fields out of range");
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> busy) else $error("not busy while emitting");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the month calendar day generator: scoreboard class plus drivers.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcdg_pkg::*;

  // one day beat as seen on the result ports
  typedef struct packed {
    logic [4:0] dom;
    logic [2:0] wday;
    logic [2:0] market;
    logic [2:0] row;
    logic       hol;
    logic [1:0] color;
    logic       last;
  } day_beat_t;

  // Calendar predictor and scoreboard. Holds its own copy of the holiday
  // bitmap and a FIFO of the day beats still owed by the block.
  class calendar_scoreboard;
    bit [30:0]  holiday_bits [12];
    day_beat_t  owed_days [$];
    int         errors;

    function new();
      foreach (holiday_bits[i]) holiday_bits[i] = '0;
      errors = 0;
    endfunction

    function int unsigned leaps_greg(int unsigned y);
      return y / 4 - y / 100 + y / 400;
    endfunction

    function bit is_leap(int unsigned y);
      if (y > 1581) return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      return (y % 4) == 0;
    endfunction

    // days in years 1..y, Julian up to 1581, Gregorian after, ten days dropped
    function int unsigned days_thru(int unsigned y);
      int unsigned jul;
      int unsigned d;
      jul = (y < 1581) ? y : 1581;
      d = 365 * jul + jul / 4;
      if (y >= 1582) begin
        d += 365 * (y - 1581) + (leaps_greg(y) - leaps_greg(1581));
        d -= 10;
      end
      return d;
    endfunction

    function int unsigned days_in(int unsigned m, bit leap);
      int unsigned lens [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && leap) return 29;
      return lens[m - 1];
    endfunction

    // accepted command beat: update the bitmap or queue the month's days
    function void note_input(bit cmd, bit [13:0] yr, bit [3:0] mo, bit [4:0] dy);
      int unsigned y;
      int unsigned base;
      int unsigned len;
      int unsigned cnt;
      int unsigned r;
      bit          leap;
      day_beat_t   b;
      if (mo < 1 || mo > 12) return;           // bad month: nothing at all
      if (cmd == CMD_ADD_HOLIDAY) begin
        if (dy != 0) holiday_bits[mo - 1][dy - 1] = 1'b1;
        return;
      end
      y = yr;
      if (y < 1) y = 1;
      if (y > YEAR_LIMIT) y = YEAR_LIMIT;
      leap = is_leap(y);
      base = days_thru(y - 1);
      for (int m = 1; m < mo; m++) base += days_in(m, leap);
      len = days_in(mo, leap);
      r = 0;
      for (int unsigned d = 1; d <= len; d++) begin
        cnt = base + d;
        b.dom    = d[4:0];
        b.wday   = 3'((cnt + 5) % 7);
        b.market = 3'(cnt % 5);
        b.row    = r[2:0];
        b.hol    = holiday_bits[mo - 1][d - 1];
        if (b.hol || b.wday == WD_SUN) b.color = CLR_RED;
        else if (b.wday == WD_FRI)     b.color = CLR_GREEN;
        else                           b.color = CLR_BLACK;
        b.last   = (d == len);
        owed_days.push_back(b);
        if (b.wday == WD_SAT) r++;
      end
    endfunction

    function void report(string name, int unsigned exp_v, int unsigned got_v);
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    endfunction

    function void check_result(day_beat_t got);
      day_beat_t exp_b;
      if (owed_days.size() == 0) begin
        $display("%0t: day beat with none owed: expected nothing, actual day %0d",
                 $time, got.dom);
        errors++;
        return;
      end
      exp_b = owed_days.pop_front();
      if (got.dom    !== exp_b.dom)    report("day_of_month", exp_b.dom, got.dom);
      if (got.wday   !== exp_b.wday)   report("weekday", exp_b.wday, got.wday);
      if (got.market !== exp_b.market) report("market_day", exp_b.market, got.market);
      if (got.row    !== exp_b.row)    report("week_row", exp_b.row, got.row);
      if (got.hol    !== exp_b.hol)    report("holiday_flag", exp_b.hol, got.hol);
      if (got.color  !== exp_b.color)  report("color_class", exp_b.color, got.color);
      if (got.last   !== exp_b.last)   report("last_day", exp_b.last, got.last);
    endfunction

    function int pending();
      return owed_days.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [13:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic        out_valid;
  logic [4:0]  out_day_of_month;
  logic [2:0]  out_weekday;
  logic [2:0]  out_market_day;
  logic [2:0]  out_week_row;
  logic        out_holiday_flag;
  logic [1:0]  out_color_class;
  logic        out_last_day;

  calendar_scoreboard sb = new();

  month_calendar_day_generator_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day           (in_day),
    .out_valid        (out_valid),
    .out_day_of_month (out_day_of_month),
    .out_weekday      (out_weekday),
    .out_market_day   (out_market_day),
    .out_week_row     (out_week_row),
    .out_holiday_flag (out_holiday_flag),
    .out_color_class  (out_color_class),
    .out_last_day     (out_last_day)
  );

  // 2 ns clock
  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Result monitor: every strobe is a beat, the receiver never stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result('{out_day_of_month, out_weekday, out_market_day, out_week_row,
                        out_holiday_flag, out_color_class, out_last_day});
    end
  end

  // Sender idle length: mostly back to back or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Drive one command beat and hold it until accepted (start high, busy low).
  // start stays high on exit; it is only dropped when a gap follows.
  task automatic send_cmd(input logic cmd, input logic [13:0] yr, input logic [3:0] mo,
                          input logic [4:0] dy, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_year    <= yr;
    in_month   <= mo;
    in_day     <= dy;
    do @(posedge clk); while (busy);
    sb.note_input(cmd, yr, mo, dy);
  endtask

  // Years near the calendar-rule edges and the year range ends.
  function automatic logic [13:0] pick_year();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 14'($urandom_range(1, 9999));
    if (r < 55) return 14'($urandom_range(1, 12));
    if (r < 70) return 14'($urandom_range(1575, 1610));
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       return 14'($urandom_range(1695, 1705));
        1:       return 14'($urandom_range(1895, 1905));
        2:       return 14'($urandom_range(1995, 2030));
        default: return 14'($urandom_range(2395, 2405));
      endcase
    end
    if (r < 88) return 14'($urandom_range(9990, 9999));
    return 14'($urandom_range(0, 16383));   // includes saturation and year zero
  endfunction

  // Month field: mostly legal, some out-of-range codes.
  function automatic logic [3:0] pick_month();
    if ($urandom_range(0, 99) < 88) return 4'($urandom_range(1, 12));
    return 4'($urandom_range(0, 15));
  endfunction

  // Stimulus
  initial begin
    int gap;
    start      <= 1'b0;
    in_command <= CMD_ADD_HOLIDAY;
    in_year    <= '0;
    in_month   <= '0;
    in_day     <= '0;
    rst_n      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: holiday corners
    send_cmd(CMD_ADD_HOLIDAY, 14'd0,     4'd1,  5'd1,  0);
    send_cmd(CMD_ADD_HOLIDAY, 14'd16383, 4'd12, 5'd31, 1);
    send_cmd(CMD_ADD_HOLIDAY, 14'd0,     4'd2,  5'd30, 0);  // past month end
    send_cmd(CMD_ADD_HOLIDAY, 14'd0,     4'd0,  5'd5,  0);  // bad month
    send_cmd(CMD_ADD_HOLIDAY, 14'd0,     4'd13, 5'd6,  2);
    send_cmd(CMD_ADD_HOLIDAY, 14'd0,     4'd15, 5'd7,  0);
    send_cmd(CMD_ADD_HOLIDAY, 14'd0,     4'd3,  5'd0,  0);  // day zero
    send_cmd(CMD_ADD_HOLIDAY, 14'd0,     4'd1,  5'd1,  0);  // already marked
    send_cmd(CMD_ADD_HOLIDAY, 14'd0,     4'd10, 5'd4,  0);
    // Directed: generate corners
    send_cmd(CMD_GENERATE, 14'd0,     4'd1,  5'd31, 0);  // year zero -> one
    send_cmd(CMD_GENERATE, 14'd1,     4'd12, 5'd0,  0);
    send_cmd(CMD_GENERATE, 14'd1580,  4'd2,  5'd0,  3);  // Julian leap
    send_cmd(CMD_GENERATE, 14'd1581,  4'd12, 5'd0,  0);
    send_cmd(CMD_GENERATE, 14'd1582,  4'd10, 5'd0,  0);
    send_cmd(CMD_GENERATE, 14'd1583,  4'd1,  5'd0,  0);  // ten days dropped
    send_cmd(CMD_GENERATE, 14'd1600,  4'd2,  5'd0,  0);
    send_cmd(CMD_GENERATE, 14'd1700,  4'd2,  5'd0,  1);
    send_cmd(CMD_GENERATE, 14'd2000,  4'd2,  5'd0,  0);
    send_cmd(CMD_GENERATE, 14'd2023,  4'd2,  5'd0,  0);
    send_cmd(CMD_GENERATE, 14'd9999,  4'd12, 5'd0,  0);
    send_cmd(CMD_GENERATE, 14'd16383, 4'd4,  5'd0,  0);  // saturates
    send_cmd(CMD_GENERATE, 14'd2024,  4'd0,  5'd0,  0);  // no days
    send_cmd(CMD_GENERATE, 14'd2024,  4'd15, 5'd0,  0);
    send_cmd(CMD_GENERATE, 14'd2024,  4'd13, 5'd0,  5);

    // Random: mostly month generation, holidays sprinkled in
    for (int i = 0; i < 270; i++) begin
      // back-to-back stretch
      gap = (i >= 60 && i < 100) ? 0 : pick_gap();
      // one full drain before going on
      if (i == 135) begin
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        gap = 0;
      end
      if ($urandom_range(0, 99) < 30) begin
        send_cmd(CMD_ADD_HOLIDAY, 14'($urandom), pick_month(),
                 ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, 31)), gap);
      end else begin
        send_cmd(CMD_GENERATE, pick_year(), pick_month(), 5'($urandom), gap);
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mcdg_pkg.sv
sv/mcdg_calc.sv
sv/month_calendar_day_generator_unit.sv
dv/tb_top.sv
